/* rtl/blist_pkg.sv */
// ----------------------------------------------------------------------------
// blist_pkg: shared types and constants of the bounded ordered list
// Request codes, sequencer states, cell commands, and the port widths of
// the stream interfaces.
// ----------------------------------------------------------------------------
package blist_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ELEM_W   = 8;
    localparam int POS_W    = 4;
    localparam int OCC_W    = 5;
    localparam int REQ_W    = 3;

    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 4;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_APPEND = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_SEARCH = 3'd3,
        REQ_DUMP   = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DUMP
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROT_L,
        CELL_ROT_R
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [ELEM_W-1:0]  key;
    } cell_ctl_t;

    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
        logic gt;
        logic last;
    } cell_flags_t;

endpackage

/* rtl/blist_cell.sv */
// ----------------------------------------------------------------------------
// blist_cell: one storage cell of the ordered list
// Holds one element, compares it against the broadcast key, and takes a
// value from its left or right neighbor to shift or rotate the row.
// ----------------------------------------------------------------------------
module blist_cell #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  logic                                 clk,
    input  blist_pkg::cell_ctl_t                 ctl,
    input  logic [$clog2(CAPACITY+1)-1:0]        count,
    input  logic                                 at,
    input  logic                                 above,
    input  logic [blist_pkg::ELEM_W-1:0]         left_val,
    input  logic [blist_pkg::ELEM_W-1:0]         right_val,
    input  logic [blist_pkg::ELEM_W-1:0]         head_val,
    output logic [blist_pkg::ELEM_W-1:0]         val,
    output blist_pkg::cell_flags_t               flags
);
    import blist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

    logic [ELEM_W-1:0] val_reg;
    logic [ELEM_W-1:0] val_next;

    assign val = val_reg;

    always_comb
    begin
        flags.valid = (IDX_C < count);
        flags.last  = (count == NEXT_C);
        flags.lt    = flags.valid && ($signed(val_reg) < $signed(ctl.key));
        flags.eq    = flags.valid && (val_reg == ctl.key);
        flags.gt    = flags.valid && ($signed(val_reg) > $signed(ctl.key));
    end

    always_comb
    begin
        val_next = val_reg;
        case (ctl.cmd)
            CELL_INSERT:
            begin
                if (above)
                    val_next = left_val;
                else if (at)
                    val_next = ctl.key;
            end
            CELL_REMOVE:
            begin
                if (at || above)
                    val_next = right_val;
            end
            CELL_ROT_L:
            begin
                // the tail cell takes the head value, so the head wraps around to the tail
                if (flags.last)
                    val_next = head_val;
                else if (flags.valid)
                    val_next = right_val;
            end
            CELL_ROT_R:
            begin
                if (flags.valid)
                    val_next = left_val;
            end
            default:
                val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

/* rtl/blist_first.sv */
// ----------------------------------------------------------------------------
// blist_first: first-hit locator across the cell row
// Isolates the lowest set bit of the hit vector with one subtract, marks
// the cells above it, and encodes its index.
// ----------------------------------------------------------------------------
module blist_first #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF
) (
    input  logic [CAPACITY-1:0]              hits,
    output logic [CAPACITY-1:0]              first,
    output logic [CAPACITY-1:0]              above,
    output logic                             any,
    output logic [$clog2(CAPACITY)-1:0]      index
);
    import blist_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    logic [CAPACITY-1:0] hits_dec;
    logic [CAPACITY-1:0] low_mask;

    // low_mask covers bit 0 up to and including the lowest hit
    assign hits_dec = hits - CAPACITY'(1);
    assign low_mask = hits ^ hits_dec;
    assign first    = hits & low_mask;
    assign above    = ~low_mask;
    assign any      = |hits;

    always_comb
    begin
        index = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (first[j])
                index = index | IDX_W'(j);
        end
    end

endmodule

/* rtl/bounded_ordered_list_unit.sv */
// ----------------------------------------------------------------------------
// bounded_ordered_list_unit: ordered list of signed bytes in a row of cells
// Insert, append, remove, search and dump over a list of up to CAPACITY
// elements, one cell per position.
// ----------------------------------------------------------------------------
// A request word is taken in the idle state. For an insert, append, remove,
// search or unused code, once the output register is free every cell
// compares against the key in parallel, the first-hit subtract across the
// row picks the place, and on an insert, append or remove the row shifts by
// one position. A dump then rotates the row by one cell per cycle while the
// output register is free, sending out the head cell (ascending) or the tail
// cell (descending), so after count steps the list is back in place; an
// empty dump gives one marker word. A new request word is taken as soon as
// the previous one is in the output register, even while that result still
// waits on m_axis_tready. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module bounded_ordered_list_unit #(
    parameter int CAPACITY = blist_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // value
    input  logic [blist_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // req_type [2:0], descending [3]
    input  logic [blist_pkg::S_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // position [3:0], element [11:4], occupancy [16:12], zero fill
    output logic [blist_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // ok [0], is_empty [1]
    output logic [blist_pkg::M_USER_W-1:0]    m_axis_tuser,
    output logic                              m_axis_tlast
);
    import blist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [REQ_W-1:0]   req_reg;
    logic [ELEM_W-1:0]  key_reg;
    logic               desc_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [IDX_W-1:0]   step_reg;
    logic [IDX_W-1:0]   step_next;

    logic               out_valid_reg;
    logic               out_ok_reg;
    logic               out_ok_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [ELEM_W-1:0]  out_elem_reg;
    logic [ELEM_W-1:0]  out_elem_next;
    logic [OCC_W-1:0]   out_occ_reg;
    logic               out_empty_reg;
    logic               out_empty_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic               out_load;
    logic               out_free;

    logic [CNT_W-1:0]       pos_src;
    logic [CNT_W+POS_W-1:0] pos_wide;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    cell_ctl_t          ctl;
    cell_flags_t        cell_flags [CAPACITY];
    logic [ELEM_W-1:0]  cell_val   [CAPACITY];

    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] lt_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] hit_vec;
    logic [CAPACITY-1:0] at_vec;
    logic [CAPACITY-1:0] above_vec;
    logic                hit_any;
    logic [IDX_W-1:0]    hit_idx;

    logic [ELEM_W-1:0]  head_val;
    logic [ELEM_W-1:0]  tail_val;
    logic               tail_lt;
    logic               head_gt;
    logic               full;
    logic               is_tail_step;

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        logic [ELEM_W-1:0] left_val;
        logic [ELEM_W-1:0] right_val;

        if (j == 0)
        begin : g_head
            assign left_val = tail_val;
        end
        else
        begin : g_inner_l
            assign left_val = cell_val[j-1];
        end

        if (j == CAPACITY - 1)
        begin : g_end
            assign right_val = '0;
        end
        else
        begin : g_inner_r
            assign right_val = cell_val[j+1];
        end

        blist_cell #(
            .CAPACITY (CAPACITY),
            .IDX      (j)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count_reg),
            .at        (at_vec[j]),
            .above     (above_vec[j]),
            .left_val  (left_val),
            .right_val (right_val),
            .head_val  (head_val),
            .val       (cell_val[j]),
            .flags     (cell_flags[j])
        );
    end

    assign head_val = cell_val[0];
    assign head_gt  = cell_flags[0].gt;
    assign full     = (count_reg == FULL_C);

    always_comb
    begin
        tail_val = '0;
        tail_lt  = 1'b0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            valid_vec[j] = cell_flags[j].valid;
            lt_vec[j]    = cell_flags[j].lt;
            eq_vec[j]    = cell_flags[j].eq;
            if (cell_flags[j].last)
                tail_val = tail_val | cell_val[j];
            tail_lt = tail_lt | (cell_flags[j].last & cell_flags[j].lt);
        end
    end

    // candidate places; the lowest one wins
    always_comb
    begin
        hit_vec = '0;
        case (req_reg)
            REQ_INSERT:
            begin
                if (count_reg == '0 || head_gt)
                    hit_vec = '1;
                else if (tail_lt)
                    hit_vec = ~valid_vec;
                else
                    for (int j = 1; j < CAPACITY; j++)
                        hit_vec[j] = !valid_vec[j] || !(lt_vec[j-1] && lt_vec[j]);
            end
            REQ_APPEND:
                hit_vec = ~valid_vec;
            REQ_REMOVE, REQ_SEARCH:
                hit_vec = eq_vec;
            default:
                hit_vec = '0;
        endcase
    end

    blist_first #(
        .CAPACITY (CAPACITY)
    ) u_first (
        .hits  (hit_vec),
        .first (at_vec),
        .above (above_vec),
        .any   (hit_any),
        .index (hit_idx)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign is_tail_step  = ((CNT_W'(step_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg  <= s_axis_tuser[REQ_W-1:0];
            key_reg  <= s_axis_tdata[ELEM_W-1:0];
            desc_reg <= s_axis_tuser[REQ_W];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        ctl.cmd        = CELL_HOLD;
        ctl.key        = key_reg;
        out_load       = 1'b0;
        out_ok_next    = 1'b0;
        out_elem_next  = '0;
        out_empty_next = 1'b0;
        out_last_next  = 1'b1;
        pos_src        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                    out_load   = 1'b1;
                    case (req_reg)
                        REQ_INSERT, REQ_APPEND:
                        begin
                            if (!full)
                            begin
                                ctl.cmd     = CELL_INSERT;
                                count_next  = count_reg + CNT_W'(1);
                                out_ok_next = 1'b1;
                                pos_src     = CNT_W'(hit_idx);
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (hit_any)
                            begin
                                ctl.cmd     = CELL_REMOVE;
                                count_next  = count_reg - CNT_W'(1);
                                out_ok_next = 1'b1;
                                pos_src     = CNT_W'(hit_idx);
                            end
                        end
                        REQ_SEARCH:
                        begin
                            out_ok_next = hit_any;
                            if (hit_any)
                                pos_src = CNT_W'(hit_idx);
                        end
                        REQ_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_ok_next    = 1'b1;
                                out_empty_next = 1'b1;
                            end
                            else
                            begin
                                // no word yet; the rotation sends them out
                                out_load   = 1'b0;
                                state_next = ST_DUMP;
                                step_next  = '0;
                            end
                        end
                        default:
                            out_ok_next = 1'b0;
                    endcase
                end
            end
            ST_DUMP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_ok_next   = 1'b1;
                    out_last_next = is_tail_step;
                    if (desc_reg)
                    begin
                        ctl.cmd       = CELL_ROT_R;
                        out_elem_next = tail_val;
                        pos_src       = count_reg - CNT_W'(1) - CNT_W'(step_reg);
                    end
                    else
                    begin
                        ctl.cmd       = CELL_ROT_L;
                        out_elem_next = head_val;
                        pos_src       = CNT_W'(step_reg);
                    end
                    if (is_tail_step)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + IDX_W'(1);
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    assign pos_wide = {{POS_W{1'b0}}, pos_src};
    assign occ_wide = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ok_reg    <= out_ok_next;
            out_pos_reg   <= pos_wide[POS_W-1:0];
            out_elem_reg  <= out_elem_next;
            out_occ_reg   <= occ_wide[OCC_W-1:0];
            out_empty_reg <= out_empty_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(M_DATA_W - POS_W - ELEM_W - OCC_W){1'b0}},
                            out_occ_reg, out_elem_reg, out_pos_reg};
    assign m_axis_tuser  = {out_empty_reg, out_ok_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_C)
        else $error("list holds more elements than cells");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == ST_EXEC)
        else $error("accepted word did not start execution");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=>
            (count_reg == $past(count_reg)) ||
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            ($past(count_reg) == count_reg + CNT_W'(1)))
        else $error("count moved by more than one in one request");

    a_dump_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DUMP |=> $stable(count_reg))
        else $error("count changed during a dump");

    a_single_place: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(at_vec))
        else $error("more than one cell selected as the place");

endmodule
